/* src/ppid_pkg.sv */
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared types and constants for the position PID controller with clamps.
// ----------------------------------------------------------------------------
package ppid_pkg;

  // Field widths fixed by the register map and the result beat
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 10;
  localparam int OLIM_W   = 8;
  localparam int ISUM_W   = 11;
  localparam int DRIVE_W  = 9;
  localparam int DIR_W    = 2;
  localparam int CFG_IDX_W = 3;

  // Reset values of the configuration registers
  localparam int              TARGET_RST = 1000;
  localparam logic [GAIN_W-1:0]  KP_RST   = 16'd410;
  localparam logic [GAIN_W-1:0]  KD_RST   = 16'd26624;
  localparam logic [GAIN_W-1:0]  KI_RST   = 16'd0;
  localparam logic [LIMIT_W-1:0] ILIM_RST = 10'd50;
  localparam logic [LIMIT_W-1:0] DB_RST   = 10'd2;
  localparam logic [OLIM_W-1:0]  OLIM_RST = 8'd30;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET   = 3'd0,
    REG_KP       = 3'd1,
    REG_KD       = 3'd2,
    REG_KI       = 3'd3,
    REG_ILIM     = 3'd4,
    REG_DEADBAND = 3'd5,
    REG_OLIM     = 3'd6
  } cfg_reg_e;

  // Direction code driven to the bridge enables
  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_NEG  = 2'd1,
    DIR_POS  = 2'd2
  } dir_e;

  // Gains and output clamp used by the weighting stage
  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] kd;
    logic [GAIN_W-1:0] ki;
    logic [OLIM_W-1:0] olim;
  } gains_t;

  // Integral clamp settings used by the error stage
  typedef struct packed {
    logic [LIMIT_W-1:0] ilim;
    logic [LIMIT_W-1:0] deadband;
  } integ_cfg_t;

endpackage

/* src/ppid_err.sv */
// ----------------------------------------------------------------------------
// ppid_err
// Error stage: error, error difference and clamped integral (cleared inside the deadband), registered.
// ----------------------------------------------------------------------------
module ppid_err
  import ppid_pkg::*;
#(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic signed [POSITION_WIDTH-1:0] pos_i,
  input  logic signed [POSITION_WIDTH-1:0] target_i,
  input  integ_cfg_t                       cfg_i,
  output logic signed [POSITION_WIDTH:0]   err_o,
  output logic signed [POSITION_WIDTH+1:0] diff_o,
  output logic signed [ISUM_W-1:0]         isum_o
);

  localparam int EW = POSITION_WIDTH + 1;
  localparam int SW = POSITION_WIDTH + 2;

  // err_q doubles as the previous error for the next beat
  logic signed [EW-1:0]     err_q, err_d;
  logic signed [SW-1:0]     diff_q, diff_d;
  logic signed [ISUM_W-1:0] isum_q, isum_d;

  logic signed [SW-1:0] sum_raw, ilim_s;
  logic signed [EW-1:0] db_s;
  logic                 in_band;

  always_comb begin
    err_d   = EW'(target_i) - EW'(pos_i);
    diff_d  = SW'(err_d) - SW'(err_q);
    sum_raw = SW'(isum_q) + SW'(err_d);
    ilim_s  = $signed({{(SW-LIMIT_W){1'b0}}, cfg_i.ilim});
    db_s    = $signed({{(EW-LIMIT_W){1'b0}}, cfg_i.deadband});
    in_band = (err_d <= db_s) && (err_d >= -db_s);
    if (in_band) begin
      isum_d = '0;
    end else if (sum_raw > ilim_s) begin
      isum_d = ISUM_W'(ilim_s);
    end else if (sum_raw < -ilim_s) begin
      isum_d = ISUM_W'(-ilim_s);
    end else begin
      isum_d = ISUM_W'(sum_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q  <= '0;
      diff_q <= '0;
      isum_q <= '0;
    end else if (load_i) begin
      err_q  <= err_d;
      diff_q <= diff_d;
      isum_q <= isum_d;
    end
  end

  assign err_o  = err_q;
  assign diff_o = diff_q;
  assign isum_o = isum_q;

endmodule

/* src/ppid_mac.sv */
// ----------------------------------------------------------------------------
// ppid_mac
// Weighting stage: gain products, exact sum, truncate toward zero, saturate.
// ----------------------------------------------------------------------------
module ppid_mac
  import ppid_pkg::*;
#(
  parameter int POSITION_WIDTH = 24,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             load_i,
  input  logic signed [POSITION_WIDTH:0]   err_i,
  input  logic signed [POSITION_WIDTH+1:0] diff_i,
  input  logic signed [ISUM_W-1:0]         isum_i,
  input  gains_t                           gains_i,
  output logic signed [DRIVE_W-1:0]        drive_o,
  output logic [DIR_W-1:0]                 dir_o
);

  localparam int PW_KP = POSITION_WIDTH + 1 + GAIN_W + 1;
  localparam int PW_KD = POSITION_WIDTH + 2 + GAIN_W + 1;
  localparam int PW_KI = ISUM_W + GAIN_W + 1;
  localparam int AW    = PW_KD + 2;
  localparam int QW    = AW - GAIN_FRAC_BITS;
  localparam logic signed [AW-1:0] RND = AW'((1 << GAIN_FRAC_BITS) - 1);

  logic signed [PW_KP-1:0] p_kp;
  logic signed [PW_KD-1:0] p_kd;
  logic signed [PW_KI-1:0] p_ki;
  logic signed [AW-1:0]    acc, acc_b;
  logic signed [QW-1:0]    quo, olim_s;
  logic signed [DRIVE_W-1:0] drive_d, drive_q;
  dir_e                    dir_d, dir_q;

  always_comb begin
    p_kp  = $signed({1'b0, gains_i.kp}) * err_i;
    p_kd  = $signed({1'b0, gains_i.kd}) * diff_i;
    p_ki  = $signed({1'b0, gains_i.ki}) * isum_i;
    acc   = AW'(p_kp) + AW'(p_kd) + AW'(p_ki);
    // bias negatives so the shift truncates toward zero
    acc_b = acc[AW-1] ? (acc + RND) : acc;
    quo   = acc_b[AW-1:GAIN_FRAC_BITS];
    olim_s = $signed({{(QW-OLIM_W){1'b0}}, gains_i.olim});
    if (quo > olim_s) begin
      drive_d = DRIVE_W'(olim_s);
    end else if (quo < -olim_s) begin
      drive_d = DRIVE_W'(-olim_s);
    end else begin
      drive_d = DRIVE_W'(quo);
    end
    if (drive_d < 0) begin
      dir_d = DIR_NEG;
    end else if (drive_d > 0) begin
      dir_d = DIR_POS;
    end else begin
      dir_d = DIR_STOP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      drive_q <= drive_d;
      dir_q   <= dir_d;
    end
  end

  assign drive_o = drive_q;
  assign dir_o   = dir_q;

endmodule

/* src/position_pid_with_clamps.sv */
// Pipeline: an input beat passes the error stage, then the weighting stage, to the result beat.
// Throughput: 1 beat per cycle; both stages advance together whenever the
// result register is empty or drained in the same cycle.
// Reset: asynchronous, active low; clears both valid flags, the previous
// error and the integral, and loads the default gains and limits.
// ----------------------------------------------------------------------------
// position_pid_with_clamps
// Position PID controller with integral clamp, deadband and output saturation.
// ----------------------------------------------------------------------------
module position_pid_with_clamps
  import ppid_pkg::*;
#(
  parameter int POSITION_WIDTH = 24,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [POSITION_WIDTH-1:0]        cfg_data_i,
  // position beats in
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [POSITION_WIDTH-1:0] measured_position_i,
  // drive beats out
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [DRIVE_W-1:0]        drive_value_o,
  output logic [DIR_W-1:0]                 direction_o
);

  // --------------------------------------------------------------------------
  // Configuration registers: wide writes keep only each register's low bits.
  // --------------------------------------------------------------------------
  logic signed [POSITION_WIDTH-1:0] target_q;
  gains_t                           gains_q;
  integ_cfg_t                       integ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q         <= POSITION_WIDTH'(TARGET_RST);
      gains_q.kp       <= KP_RST;
      gains_q.kd       <= KD_RST;
      gains_q.ki       <= KI_RST;
      gains_q.olim     <= OLIM_RST;
      integ_q.ilim     <= ILIM_RST;
      integ_q.deadband <= DB_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TARGET:   target_q         <= $signed(cfg_data_i);
        REG_KP:       gains_q.kp       <= cfg_data_i[GAIN_W-1:0];
        REG_KD:       gains_q.kd       <= cfg_data_i[GAIN_W-1:0];
        REG_KI:       gains_q.ki       <= cfg_data_i[GAIN_W-1:0];
        REG_ILIM:     integ_q.ilim     <= cfg_data_i[LIMIT_W-1:0];
        REG_DEADBAND: integ_q.deadband <= cfg_data_i[LIMIT_W-1:0];
        REG_OLIM:     gains_q.olim     <= cfg_data_i[OLIM_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. The result register drains or refills every cycle
  // the consumer takes it, so the error stage behind it never bubbles.
  // --------------------------------------------------------------------------
  logic s1_valid_q, out_valid_q;
  logic out_go, s1_go, in_go;

  assign out_go     = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && out_go;
  assign in_ready_o = !s1_valid_q || out_go;
  assign in_go      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // hold the error stage when the result register is stuck
      if (in_go) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Error stage: updates the previous error and the integral on every
  // accepted beat, so the next accepted beat sees the updated values.
  // --------------------------------------------------------------------------
  logic signed [POSITION_WIDTH:0]   err;
  logic signed [POSITION_WIDTH+1:0] diff;
  logic signed [ISUM_W-1:0]         isum;

  ppid_err #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_err (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_go),
    .pos_i    (measured_position_i),
    .target_i (target_q),
    .cfg_i    (integ_q),
    .err_o    (err),
    .diff_o   (diff),
    .isum_o   (isum)
  );

  // --------------------------------------------------------------------------
  // Weighting stage: products, truncation and saturation into the result
  // register, loaded when the error stage hands over its beat.
  // --------------------------------------------------------------------------
  ppid_mac #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .load_i  (s1_go),
    .err_i   (err),
    .diff_i  (diff),
    .isum_i  (isum),
    .gains_i (gains_q),
    .drive_o (drive_value_o),
    .dir_o   (direction_o)
  );

endmodule

/* src/ppid_checker.sv */
// ----------------------------------------------------------------------------
// ppid_checker
// Port-level checks on the position PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module ppid_checker
  import ppid_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [DRIVE_W-1:0] drive_value_o,
  input logic [DIR_W-1:0]          direction_o
);

  // direction follows the sign of the drive value
  a_dir_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (drive_value_o == 0 && direction_o == DIR_STOP) ||
      (drive_value_o < 0 && direction_o == DIR_NEG) ||
      (drive_value_o > 0 && direction_o == DIR_POS))
    else $error("direction does not match drive sign");

  // out_valid_o is high once an accepted beat has passed the error stage and the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> ##1 out_valid_o)
    else $error("result beat missing after accepted input");

  // input backpressure only when the output is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output can drain");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(drive_value_o) && $stable(direction_o)))
    else $error("stalled result beat changed");

endmodule

bind position_pid_with_clamps ppid_checker u_ppid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .drive_value_o (drive_value_o),
  .direction_o   (direction_o)
);
